// ----- sv/u2l_pkg.sv -----
package u2l_pkg;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [7:0] QMark = 8'h3F;

    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
    } u2l_res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } u2l_qstat_t;

    function automatic logic [1:0] lead_len(input logic [7:0] b);
        logic [1:0] len;
        len = 2'd0;
        if (b[7:5] == 3'b110) len = 2'd1;
        else if (b[7:4] == 4'b1110) len = 2'd2;
        else if (b[7:3] == 5'b11110) len = 2'd3;
        return len;
    endfunction

endpackage

// ----- sv/utf8_to_latin1_transcoder_unit.sv -----
// utf8 to latin1 transcoder
// input channel s_*: one utf8 byte per beat, s_in_last on the final byte of a string
// output channel m_*: result bytes, m_run_last on the last result of an input beat
// cfg_wr_en / cfg_wr_data write the mode bit (1 = latin1, 0 = passthrough); the user
// must write it only while idle, the block does not enforce this; an input beat causes
// zero, one or two results; a front stage decodes the beat and pushes its results as
// one entry into a 4-entry queue, a back stage drains the queue into an output register
// that drives m_*; a result goes through its queue entry and then that output register
// throughput: one input beat per cycle while the queue is not full; an entry holding
// two results leaves the queue only once both have passed the single output register
// reset: mode returns to latin1, held sequence, queue and output are cleared
// when the receiver stalls the queue fills and s_ready drops once 4 entries wait
module utf8_to_latin1_transcoder_unit import u2l_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last
);

    logic       push, pop;
    u2l_res_t   push_data, head;
    u2l_qstat_t q_stat;

    u2l_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .q_stat      (q_stat),
        .push        (push),
        .push_data   (push_data)
    );

    u2l_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    u2l_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last)
    );

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_stat.full) else $error("push into full queue");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_stat.empty) else $error("pop from empty queue");

    a_second_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_run_last) |=> m_valid) else $error("second result missing");

    a_pair_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_run_last) |-> !q_stat.empty) else $error("pair entry left queue early");

endmodule

// ----- sv/u2l_front.sv -----
module u2l_front import u2l_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    input  u2l_qstat_t q_stat,
    output logic       push,
    output u2l_res_t   push_data
);

    logic       mode_reg;
    logic [2:0] held_cnt_reg, held_cnt_next;
    logic [1:0] need_cnt_reg, need_cnt_next;
    logic [7:0] held_reg [3];

    logic       accept;
    logic       emit;
    logic [7:0] c1, c2, cp_byte;
    logic       complete;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign push    = accept && emit;

    assign c1       = (held_cnt_reg == 3'd1) ? s_in_byte : held_reg[1];
    assign c2       = (held_cnt_reg == 3'd2) ? s_in_byte : held_reg[2];
    assign complete = held_cnt_reg >= {1'b0, need_cnt_reg};

    // code point of the held sequence completed by this beat
    always_comb begin
        cp_byte = QMark;
        case (need_cnt_reg)
            2'd1: begin
                if (held_reg[0][4:2] == 3'd0) cp_byte = {held_reg[0][1:0], c1[5:0]};
            end
            2'd2: begin
                if (held_reg[0][3:0] == 4'd0 && c1[5:2] == 4'd0)
                    cp_byte = {c1[1:0], c2[5:0]};
            end
            2'd3: begin
                if (held_reg[0][2:0] == 3'd0 && c1[5:0] == 6'd0 && c2[5:2] == 4'd0)
                    cp_byte = {c2[1:0], s_in_byte[5:0]};
            end
            default: cp_byte = QMark;
        endcase
    end

    always_comb begin
        emit           = 1'b0;
        push_data.two  = 1'b0;
        push_data.b0   = s_in_byte;
        push_data.b1   = s_in_byte;
        held_cnt_next  = held_cnt_reg;
        need_cnt_next  = need_cnt_reg;
        if (!mode_reg) begin
            emit          = 1'b1;
            held_cnt_next = 3'd0;
            need_cnt_next = 2'd0;
        end else if (held_cnt_reg == 3'd0) begin
            if (!s_in_byte[7]) begin
                emit = 1'b1;
            end else if (lead_len(s_in_byte) != 2'd0 && !s_in_last) begin
                held_cnt_next = 3'd1;
                need_cnt_next = lead_len(s_in_byte);
            end
        end else if (complete) begin
            emit          = 1'b1;
            push_data.b0  = cp_byte;
            held_cnt_next = 3'd0;
            need_cnt_next = 2'd0;
        end else begin
            held_cnt_next = held_cnt_reg + 3'd1;
            if (s_in_last) begin
                // incomplete at end: bytes after the lead are decoded again
                if (held_cnt_reg == 3'd1) begin
                    emit = !s_in_byte[7];
                end else if (!held_reg[1][7]) begin
                    emit          = 1'b1;
                    push_data.b0  = held_reg[1];
                    push_data.two = !s_in_byte[7];
                end else if (held_reg[1][7:5] == 3'b110) begin
                    emit         = 1'b1;
                    push_data.b0 = (held_reg[1][4:2] == 3'd0) ?
                                   {held_reg[1][1:0], s_in_byte[5:0]} : QMark;
                end else begin
                    emit = !s_in_byte[7];
                end
            end
        end
        if (s_in_last) begin
            held_cnt_next = 3'd0;
            need_cnt_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= 1'b1;
            held_cnt_reg <= 3'd0;
            need_cnt_reg <= 2'd0;
        end else begin
            if (cfg_wr_en) mode_reg <= cfg_wr_data;
            if (accept) begin
                held_cnt_reg <= held_cnt_next;
                need_cnt_reg <= need_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && mode_reg) begin
            if (held_cnt_reg == 3'd0) held_reg[0] <= s_in_byte;
            else if (held_cnt_reg == 3'd1) held_reg[1] <= s_in_byte;
            else if (held_cnt_reg == 3'd2) held_reg[2] <= s_in_byte;
        end
    end

endmodule

// ----- sv/u2l_queue.sv -----
module u2l_queue import u2l_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  u2l_res_t   push_data,
    input  logic       pop,
    output u2l_res_t   head,
    output u2l_qstat_t q_stat
);

    u2l_res_t         mem_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCntW-1:0] cnt_reg;

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = cnt_reg == QCntW'(QDepth);
    assign q_stat.empty = cnt_reg == '0;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ----- sv/u2l_back.sv -----
module u2l_back import u2l_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  u2l_res_t   head,
    input  u2l_qstat_t q_stat,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last
);

    logic       m_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       phase_reg;
    logic       load;
    logic       first_of_two;

    assign load         = !q_stat.empty && (!m_valid_reg || m_ready);
    assign first_of_two = head.two && !phase_reg;
    assign pop          = load && !first_of_two;

    assign m_valid    = m_valid_reg;
    assign m_out_byte = byte_reg;
    assign m_run_last = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
            phase_reg   <= first_of_two;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= phase_reg ? head.b1 : head.b0;
            last_reg <= !first_of_two;
        end
    end

endmodule

// ----- bench/tb_utf8_to_latin1_transcoder_unit.sv -----
`timescale 1ns / 1ps

module tb_utf8_to_latin1_transcoder_unit import u2l_pkg::*; ();

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 8;
    localparam int MAX_REPORTS = 200;
    localparam int LONG_HOLD   = 300;

    localparam bit MODE_PASS   = 1'b0;
    localparam bit MODE_LATIN1 = 1'b1;

    typedef struct {
        logic [7:0] code_unit;
        logic       fin;
    } utf_beat_t;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
    } latin_beat_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_in_last;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_run_last;

    utf_beat_t   pending_beats[$];
    latin_beat_t expected_beats[$];
    utf_beat_t   next_beat;
    latin_beat_t want;
    latin_beat_t made;

    // decoder state mirrored from the block
    bit          cur_mode;
    logic [31:0] seq_word;
    int          seq_cnt;
    int          seq_need;
    logic [7:0]  step_ch [2];
    int          step_n;

    int send_idle_pct;
    int recv_stall_pct;
    int ready_hold;
    bit in_fire;

    int cycles;
    int errors;
    int beats_in;
    int results_seen;
    int bytes_queued;
    int strings_queued;
    int passthrough_beats;

    utf8_to_latin1_transcoder_unit DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_last (m_run_last)
    );

    always #4 aclk = ~aclk;

    function automatic int follow_count(input logic [7:0] b);
        if (b[7:5] == 3'b110) return 1;
        if (b[7:4] == 4'b1110) return 2;
        if (b[7:3] == 5'b11110) return 3;
        return 0;
    endfunction

    // byte 0 of w is the lead, followers above it
    function automatic logic [20:0] join_cp(input logic [31:0] w, input int n);
        logic [20:0] cp;
        int j;
        if (n == 1) cp = {16'd0, w[4:0]};
        else if (n == 2) cp = {17'd0, w[3:0]};
        else cp = {18'd0, w[2:0]};
        for (j = 1; j <= n; j++) cp = {cp[14:0], w[8*j +: 6]};
        return cp;
    endfunction

    task automatic emit(input logic [20:0] cp);
        if (step_n < 2) begin
            step_ch[step_n] = (cp <= 21'h0000FF) ? cp[7:0] : QMark;
            step_n++;
        end
    endtask

    // bytes held after a dropped lead, decoded as a string ending here
    task automatic decode_leftover(input logic [31:0] w, input int n);
        int i;
        int len;
        logic [7:0] c;
        i = 0;
        while (i < n) begin
            c = w[8*i +: 8];
            if (c < 8'h80) begin
                emit({13'd0, c});
                i++;
            end else begin
                len = follow_count(c);
                if (len != 0 && i + len < n) begin
                    emit(join_cp(w >> (8 * i), len));
                    i += len + 1;
                end else begin
                    i++;
                end
            end
        end
    endtask

    task automatic predict_beat(input logic [7:0] b, input logic fin);
        int k;
        step_n = 0;
        if (cur_mode == MODE_PASS) begin
            seq_cnt = 0;
            seq_need = 0;
            step_ch[0] = b;
            step_n = 1;
            passthrough_beats++;
        end else begin
            if (seq_cnt == 0) begin
                if (b < 8'h80) begin
                    emit({13'd0, b});
                end else if (follow_count(b) != 0 && !fin) begin
                    seq_word[7:0] = b;
                    seq_cnt = 1;
                    seq_need = follow_count(b);
                end
            end else begin
                if (seq_cnt < 4) seq_word[8*seq_cnt +: 8] = b;
                seq_cnt++;
                if (seq_cnt >= seq_need + 1 || seq_cnt >= 4) begin
                    emit(join_cp(seq_word, seq_need));
                    seq_cnt = 0;
                    seq_need = 0;
                end else if (fin) begin
                    decode_leftover(seq_word >> 8, seq_cnt - 1);
                end
            end
            if (fin) begin
                seq_cnt = 0;
                seq_need = 0;
            end
        end
        for (k = 0; k < step_n; k++) begin
            made.ch = step_ch[k];
            made.fin = (k == step_n - 1);
            expected_beats.insert(expected_beats.size(), made);
        end
    endtask

    function automatic logic [7:0] follower();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    function automatic logic [7:0] lead_of(input int len);
        case (len)
            1: begin
                return 8'($urandom_range(8'hC0, 8'hDF));
            end
            2: begin
                return 8'($urandom_range(8'hE0, 8'hEF));
            end
            default: begin
                return 8'($urandom_range(8'hF0, 8'hF7));
            end
        endcase
    endfunction

    task automatic queue_byte(input logic [7:0] b, input logic fin);
        utf_beat_t u;
        u.code_unit = b;
        u.fin = fin;
        pending_beats.insert(pending_beats.size(), u);
        bytes_queued++;
    endtask

    task automatic queue_string();
        logic [7:0] str[$];
        int chars;
        int c;
        int kind;
        int len;
        int keep;
        int j;
        chars = $urandom_range(1, 6);
        for (c = 0; c < chars; c++) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                str.insert(str.size(), 8'($urandom_range(0, 127)));
            end else if (kind < 85) begin
                len = (kind < 55) ? 1 : (kind < 72) ? 2 : 3;
                str.insert(str.size(), lead_of(len));
                for (j = 0; j < len; j++) str.insert(str.size(), follower());
            end else if (kind < 90) begin
                str.insert(str.size(), 8'($urandom_range(8'h80, 8'hBF)));
            end else if (kind < 93) begin
                str.insert(str.size(), 8'($urandom_range(8'hF8, 8'hFF)));
            end else begin
                str.insert(str.size(), 8'($urandom_range(0, 255)));
            end
        end
        // cut-off sequence at the end of the string
        if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, 3);
            str.insert(str.size(), lead_of(len));
            keep = $urandom_range(0, len - 1);
            for (j = 0; j < keep; j++) begin
                if ($urandom_range(0, 1) == 0) str.insert(str.size(), 8'($urandom_range(0, 127)));
                else str.insert(str.size(), 8'($urandom_range(0, 255)));
            end
        end
        for (j = 0; j < str.size(); j++) queue_byte(str[j], j == str.size() - 1);
        strings_queued++;
    endtask

    task automatic fill(input int n);
        int target;
        target = bytes_queued + n;
        while (bytes_queued < target) queue_string();
    endtask

    task automatic drain();
        while (pending_beats.size() != 0 || s_valid || expected_beats.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apply_mode(input bit v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_mode = v;
    endtask

    task automatic run_random(input bit m, input int snd, input int rcv, input int n,
                              input bit hold_first, input bit pause_mid);
        apply_mode(m);
        send_idle_pct = snd;
        recv_stall_pct = rcv;
        if (hold_first) ready_hold = LONG_HOLD;
        fill(n / 2);
        if (pause_mid) drain();
        fill(n - n / 2);
        drain();
    endtask

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                next_beat = pending_beats.pop_front();
                s_valid <= 1'b1;
                s_in_byte <= next_beat.code_unit;
                s_in_last <= next_beat.fin;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // output ready, with an occasional long hold
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        in_fire = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result beat, expected none actual %h/%b",
                                 $time, m_out_byte, m_run_last);
                end else begin
                    want = expected_beats.pop_front();
                    results_seen++;
                    if (m_out_byte !== want.ch) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: m_out_byte expected %h actual %h",
                                     $time, want.ch, m_out_byte);
                    end
                    if (m_run_last !== want.fin) begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: m_run_last expected %b actual %b",
                                     $time, want.fin, m_run_last);
                    end
                end
            end
            if (s_valid && s_ready) begin
                in_fire = 1'b1;
                beats_in++;
                predict_beat(s_in_byte, s_in_last);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_utf8_to_latin1_transcoder_unit: done, errors");
            $finish;
        end
    end

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        s_valid = 1'b0;
        s_in_byte = 8'h00;
        s_in_last = 1'b0;
        m_ready = 1'b0;
        cur_mode = MODE_LATIN1;
        seq_word = 32'd0;
        seq_cnt = 0;
        seq_need = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        ready_hold = 0;
        in_fire = 1'b0;
        cycles = 0;
        errors = 0;
        beats_in = 0;
        results_seen = 0;
        bytes_queued = 0;
        strings_queued = 0;
        passthrough_beats = 0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed
        apply_mode(MODE_LATIN1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'hA9, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h90, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hE0, 1'b0);
        queue_byte(8'h83, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hC3, 1'b1);
        queue_byte(8'hF4, 1'b0);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'h42, 1'b1);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'hA9, 1'b1);
        queue_byte(8'hE1, 1'b0);
        queue_byte(8'hC3, 1'b1);
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'h41, 1'b1);
        queue_byte(8'hC3, 1'b0);
        drain();
        // held lead survives a mode write
        apply_mode(MODE_LATIN1);
        queue_byte(8'hA9, 1'b1);
        drain();
        apply_mode(MODE_PASS);
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hFF, 1'b1);
        drain();

        // random
        run_random(MODE_LATIN1, 0, 0, 200, 1'b0, 1'b0);
        run_random(MODE_LATIN1, 82, 0, 160, 1'b0, 1'b0);
        run_random(MODE_LATIN1, 0, 82, 160, 1'b0, 1'b0);
        run_random(MODE_PASS, 0, 0, 100, 1'b0, 1'b0);
        run_random(MODE_LATIN1, 16, 16, 200, 1'b0, 1'b1);
        run_random(MODE_PASS, 0, 82, 100, 1'b0, 1'b0);
        run_random(MODE_LATIN1, 0, 0, 160, 1'b1, 1'b0);
        run_random(MODE_LATIN1, 82, 0, 160, 1'b0, 1'b0);
        run_random(MODE_PASS, 16, 16, 100, 1'b0, 1'b0);
        run_random(MODE_LATIN1, 16, 16, 200, 1'b0, 1'b0);
        run_random(MODE_LATIN1, 0, 82, 160, 1'b0, 1'b0);

        if (expected_beats.size() != 0) begin
            errors++;
            $display("%0t: %0d result beats expected but never seen", $time,
                     expected_beats.size());
        end

        $display("sent %0d input beats in %0d strings (%0d in passthrough), checked %0d results",
                 beats_in, strings_queued, passthrough_beats, results_seen);
        $display("both modes, sender gaps, receiver stalls, a long output hold and a drain pause");
        if (errors == 0) begin
            $display("tb_utf8_to_latin1_transcoder_unit: done, clean");
        end else begin
            $display("tb_utf8_to_latin1_transcoder_unit: done, errors");
        end
        $finish;
    end

endmodule

// ----- utf8_to_latin1_transcoder_unit.f -----
sv/u2l_pkg.sv
sv/u2l_front.sv
sv/u2l_queue.sv
sv/u2l_back.sv
sv/utf8_to_latin1_transcoder_unit.sv
bench/tb_utf8_to_latin1_transcoder_unit.sv
